@@ hw/rtl/sss_pkg.sv @@
// Shared types and constants for the score set statistics block.
// No dependencies; imported by score_set_statistics.
package sss_pkg;

  localparam int NUM_BINS  = 101;
  localparam int TOP_SCORE = 100;
  localparam int BIN_W     = 7;
  localparam int QUO_W     = 28;
  localparam int OUT_CNT_W = 21;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_RUN   = 8'b0000_0010,
    ST_FLUSH = 8'b0000_0100,
    ST_SCAN  = 8'b0000_1000,
    ST_MUL   = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    STEP_NSQ  = 3'd0,
    STEP_SS   = 3'd1,
    STEP_NN   = 3'd2,
    STEP_DEV  = 3'd3,
    STEP_MEAN = 3'd4
  } step_t;

endpackage

@@ hw/rtl/score_set_statistics.sv @@
// Score set statistics: histogram memory, running sums and a sequential finish unit.
// Depends on sss_pkg for state codes and constants.
//
//  channel | dir | fields (tdata low bit up)                              | end marker
//  in_     | in  | score[6:0], pad                                        | in_tlast
//  out_    | out | min[6:0] max[6:0] median_x2[7:0] mean[14:0] dev[13:0]  | none
//          |     | set_count[20:0]                                        |
//
// A score is taken every cycle while in_tready is high; the histogram read-modify-write is
// forwarded between neighbors. The last item of a set adds a finish with in_tready low: a
// flush, the histogram scan, three shift-add multiplies, two restoring divides, the square
// root and a load of the result. The load waits while an earlier result is still held.
// After reset a clearing pass over the 101 histogram bins holds in_tready low. The result
// register frees the input side.
module score_set_statistics
  import sss_pkg::*;
#(
  parameter int MAX_ITEMS = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // score[6:0], zero pad
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // min, max, median_x2, mean_x256, dev_x256, set_count
);

  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int SW   = CW + 7;
  localparam int QW   = CW + 14;
  localparam int PW   = 2 * CW + 14;
  localparam int DVW  = PW + 16;
  localparam int DNW  = 2 * CW;
  localparam int MCW  = $clog2(SW + 1);
  localparam int DCW  = $clog2(DVW + 1);

  state_t state_r;
  step_t  step_r;

  logic [CW-1:0]    hist_mem [NUM_BINS];
  logic [CW-1:0]    mem_rd_r;
  logic [BIN_W-1:0] mem_ra;
  logic             mem_we;
  logic [BIN_W-1:0] mem_wa;
  logic [CW-1:0]    mem_wd;

  logic [BIN_W-1:0] score_c;
  logic             in_acc;
  logic             counted;

  logic             acc_v_r;
  logic [BIN_W-1:0] acc_bin_r;
  logic             wr_v_r;
  logic [BIN_W-1:0] wr_addr_r;
  logic [CW-1:0]    wr_data_r;
  logic [CW-1:0]    acc_old;

  logic [BIN_W-1:0] min_r, max_r;
  logic [CW-1:0]    cnt_r;
  logic [SW-1:0]    sum_r;
  logic [QW-1:0]    sq_r;

  logic [BIN_W-1:0] addr_r;
  logic             scan_v_r;
  logic [BIN_W-1:0] scan_bin_r;
  logic [CW:0]      cum_r, cum_nxt, lo_need, hi_need;
  logic             lo_f_r, hi_f_r;
  logic [BIN_W-1:0] lo_bin_r, hi_bin_r;

  logic [PW-1:0]    mul_a_r, mul_p_r, mul_p_nxt;
  logic [SW-1:0]    mul_b_r;
  logic [MCW-1:0]   mul_c_r;
  logic [PW-1:0]    d_r;

  logic [DVW-1:0]   num_r;
  logic [DNW-1:0]   den_r, rem_r;
  logic [DNW:0]     rem_t;
  logic             rem_ge;
  logic [QUO_W-1:0] quo_r;
  logic [DCW-1:0]   div_c_r;
  logic [QUO_W-1:0] x_r;
  logic [14:0]      mean_r;

  logic [QUO_W-1:0] sv_r, res_r, bit_r;
  logic [QUO_W:0]   rb;

  logic             out_v_r;
  logic [71:0]      out_d_r;
  logic [CW+20:0]   cnt_ext;

  assign score_c   = (in_tdata[6:0] > 7'(TOP_SCORE)) ? 7'(TOP_SCORE) : in_tdata[6:0];
  assign in_tready = (state_r == ST_RUN);
  assign in_acc    = in_tvalid && in_tready;
  assign counted   = (cnt_r < CW'(MAX_ITEMS));
  assign acc_old   = (wr_v_r && (wr_addr_r == acc_bin_r)) ? wr_data_r : mem_rd_r;

  always_comb begin
    mem_ra = score_c;
    mem_we = 1'b0;
    mem_wa = acc_bin_r;
    mem_wd = acc_old + CW'(1);
    if ((state_r == ST_CLEAR) || (state_r == ST_SCAN)) begin
      mem_ra = addr_r;
      mem_wa = addr_r;
      mem_wd = '0;
      mem_we = (addr_r < 7'(NUM_BINS));
    end else if (acc_v_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= hist_mem[mem_ra];
  end

  assign lo_need = ({1'b0, cnt_r} + (CW+1)'(1)) >> 1;
  assign hi_need = (CW+1)'(cnt_r >> 1) + (CW+1)'(1);
  assign cum_nxt = cum_r + {1'b0, mem_rd_r};

  assign mul_p_nxt = mul_b_r[0] ? (mul_p_r + mul_a_r) : mul_p_r;
  assign rem_t     = {rem_r, num_r[DVW-1]};
  assign rem_ge    = (rem_t >= {1'b0, den_r});
  assign rb        = {1'b0, res_r} + {1'b0, bit_r};
  assign cnt_ext   = (CW+21)'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      step_r   <= STEP_NSQ;
      addr_r   <= '0;
      acc_v_r  <= 1'b0;
      wr_v_r   <= 1'b0;
      scan_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      min_r    <= 7'(TOP_SCORE);
      max_r    <= '0;
      cnt_r    <= '0;
      sum_r    <= '0;
      sq_r     <= '0;
    end else begin
      if ((state_r == ST_DONE) && (!out_v_r || out_tready)) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      acc_v_r   <= in_acc && counted;
      acc_bin_r <= score_c;
      wr_v_r    <= acc_v_r && (state_r != ST_CLEAR) && (state_r != ST_SCAN);
      wr_addr_r <= acc_bin_r;
      wr_data_r <= mem_wd;
      if (in_acc && counted) begin
        if (score_c < min_r) begin
          min_r <= score_c;
        end
        if (score_c > max_r) begin
          max_r <= score_c;
        end
        cnt_r <= cnt_r + CW'(1);
        sum_r <= sum_r + SW'(score_c);
        sq_r  <= sq_r + QW'({7'b0, score_c} * {7'b0, score_c});
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (addr_r == 7'(NUM_BINS - 1)) begin
            addr_r  <= '0;
            state_r <= ST_RUN;
          end else begin
            addr_r <= addr_r + 7'd1;
          end
        end
        ST_RUN: begin
          if (in_acc && in_tlast) begin
            state_r <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          addr_r  <= '0;
          cum_r   <= '0;
          lo_f_r  <= 1'b0;
          hi_f_r  <= 1'b0;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          scan_v_r   <= (addr_r != 7'(NUM_BINS));
          scan_bin_r <= addr_r;
          if (addr_r != 7'(NUM_BINS)) begin
            addr_r <= addr_r + 7'd1;
          end
          if (scan_v_r) begin
            cum_r <= cum_nxt;
            if (!lo_f_r && (cum_nxt >= lo_need)) begin
              lo_f_r   <= 1'b1;
              lo_bin_r <= scan_bin_r;
            end
            if (!hi_f_r && (cum_nxt >= hi_need)) begin
              hi_f_r   <= 1'b1;
              hi_bin_r <= scan_bin_r;
            end
          end
          if ((addr_r == 7'(NUM_BINS)) && !scan_v_r) begin
            addr_r  <= '0;
            state_r <= ST_MUL;
            step_r  <= STEP_NSQ;
            mul_a_r <= PW'(sq_r);
            mul_b_r <= SW'(cnt_r);
            mul_p_r <= '0;
            mul_c_r <= '0;
          end
        end
        ST_MUL: begin
          if (mul_c_r == MCW'(SW - 1)) begin
            mul_p_r <= '0;
            mul_c_r <= '0;
            case (step_r)
              STEP_NSQ: begin
                d_r     <= mul_p_nxt;
                step_r  <= STEP_SS;
                mul_a_r <= PW'(sum_r);
                mul_b_r <= sum_r;
              end
              STEP_SS: begin
                d_r     <= (d_r >= mul_p_nxt) ? (d_r - mul_p_nxt) : '0;
                step_r  <= STEP_NN;
                mul_a_r <= PW'(cnt_r);
                mul_b_r <= SW'(cnt_r);
              end
              default: begin
                den_r   <= DNW'(mul_p_nxt);
                num_r   <= {d_r, 16'b0};
                rem_r   <= '0;
                div_c_r <= '0;
                step_r  <= STEP_DEV;
                state_r <= ST_DIV;
              end
            endcase
          end else begin
            mul_p_r <= mul_p_nxt;
            mul_a_r <= mul_a_r << 1;
            mul_b_r <= mul_b_r >> 1;
            mul_c_r <= mul_c_r + MCW'(1);
          end
        end
        ST_DIV: begin
          if (div_c_r == DCW'(DVW - 1)) begin
            div_c_r <= '0;
            rem_r   <= '0;
            if (step_r == STEP_DEV) begin
              x_r    <= {quo_r[QUO_W-2:0], rem_ge};
              den_r  <= DNW'(cnt_r);
              num_r  <= DVW'({sum_r, 8'b0});
              step_r <= STEP_MEAN;
            end else begin
              mean_r  <= {quo_r[13:0], rem_ge};
              sv_r    <= x_r;
              res_r   <= '0;
              bit_r   <= QUO_W'(1) << (QUO_W - 2);
              state_r <= ST_SQRT;
            end
          end else begin
            rem_r   <= rem_ge ? DNW'(rem_t - {1'b0, den_r}) : DNW'(rem_t);
            quo_r   <= {quo_r[QUO_W-2:0], rem_ge};
            num_r   <= num_r << 1;
            div_c_r <= div_c_r + DCW'(1);
          end
        end
        ST_SQRT: begin
          if (bit_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            if ({1'b0, sv_r} >= rb) begin
              sv_r  <= QUO_W'({1'b0, sv_r} - rb);
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        ST_DONE: begin
          if (!out_v_r || out_tready) begin
            out_d_r <= {cnt_ext[OUT_CNT_W-1:0], res_r[13:0], mean_r,
                        8'({1'b0, lo_bin_r} + {1'b0, hi_bin_r}), max_r, min_r};
            min_r   <= 7'(TOP_SCORE);
            max_r   <= '0;
            cnt_r   <= '0;
            sum_r   <= '0;
            sq_r    <= '0;
            state_r <= ST_RUN;
          end
        end
        default: state_r <= ST_CLEAR;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule
